// ===== hdl/fvnp_pkg.sv =====
// Shared types and constants for the four-value nibble packer.
// Used by the front, the queue, the back and the top level; no dependencies.
package fvnp_pkg;

    // Number of entries in the queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Class codes of one value
    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_NIB1 = 2'd1;
    localparam logic [1:0] CLS_NIB2 = 2'd2;
    localparam logic [1:0] CLS_NIB4 = 2'd3;

    // Stream widths
    localparam int NIB_W    = 64;   // up to sixteen nibbles, left aligned
    localparam int NBYTES_W = 4;    // one to nine bytes per item

    // One classified item waiting to be serialized
    typedef struct packed {
        logic [7:0]          header;
        logic [NIB_W-1:0]    nibbles;
        logic [NBYTES_W-1:0] nbytes;
    } t_pack_entry;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== hdl/four_value_nibble_packer.sv =====
// Top level of the four-value nibble packer: front, queue and back.
// Depends on fvnp_pkg, fvnp_front, fvnp_queue and fvnp_back.
//
//  Channel  | Valid    | Stall    | Payload
//  ---------+----------+----------+-----------------------------------------
//  input    | i_valid  | o_stall  | i_value_a, i_value_b, i_value_c, i_value_d
//  output   | o_valid  | i_stall  | o_out_byte, o_is_last
//
// An item takes 1 + ceil(nibbles / 2) output beats, from 1 to 9 bytes; the back's
// single byte-wide output register emits one byte per cycle while i_stall is low.
// Classification is combinational; the queue registers the item on the accepting edge.
// The front accepts while the 4-entry queue has room, so input and output stall
// independently. Reset clears the queue pointers and the output valid.
module four_value_nibble_packer import fvnp_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_value_a,
    input  logic signed [15:0] i_value_b,
    input  logic signed [15:0] i_value_c,
    input  logic signed [15:0] i_value_d,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_is_last
);

    t_pack_entry front_entry;
    t_pack_entry head_entry;
    t_q_stat     qstat;
    logic        push;
    logic        pop;

    assign o_stall = qstat.full;
    assign push    = i_valid && !qstat.full;

    fvnp_front u_front (
        .i_value_a (i_value_a),
        .i_value_b (i_value_b),
        .i_value_c (i_value_c),
        .i_value_d (i_value_d),
        .o_entry   (front_entry)
    );

    fvnp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_head  (head_entry),
        .o_stat  (qstat)
    );

    fvnp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_entry),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_last  (o_is_last)
    );

endmodule

// ===== hdl/fvnp_front.sv =====
// Front of the packer: classifies the four values and lays out the nibble word.
// Depends on fvnp_pkg.
module fvnp_front import fvnp_pkg::*; (
    input  logic signed [15:0] i_value_a,
    input  logic signed [15:0] i_value_b,
    input  logic signed [15:0] i_value_c,
    input  logic signed [15:0] i_value_d,
    output t_pack_entry        o_entry
);

    logic [15:0]      raw   [4];
    logic [1:0]       cls   [4];
    logic [2:0]       cnt   [4];
    logic [15:0]      field [4];
    logic [NIB_W-1:0] word;
    logic [4:0]       pos;
    logic [4:0]       pos_rnd;
    logic [7:0]       header;

    assign raw[0] = i_value_a;
    assign raw[1] = i_value_b;
    assign raw[2] = i_value_c;
    assign raw[3] = i_value_d;

    // classify each value and left-align its nibbles
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (raw[k] == 16'h0000) begin
                cls[k] = CLS_ZERO;
            end else if (raw[k][15:3] == '0 || raw[k][15:3] == '1) begin
                cls[k] = CLS_NIB1;
            end else if (raw[k][15:7] == '0 || raw[k][15:7] == '1) begin
                cls[k] = CLS_NIB2;
            end else begin
                cls[k] = CLS_NIB4;
            end
            case (cls[k])
                CLS_ZERO: begin
                    cnt[k]   = 3'd0;
                    field[k] = 16'h0000;
                end
                CLS_NIB1: begin
                    cnt[k]   = 3'd1;
                    field[k] = {raw[k][3:0], 12'h000};
                end
                CLS_NIB2: begin
                    cnt[k]   = 3'd2;
                    field[k] = {raw[k][7:0], 8'h00};
                end
                default: begin
                    cnt[k]   = 3'd4;
                    field[k] = raw[k];
                end
            endcase
        end
    end

    // concatenate the variable-length fields, earliest value at the top
    always_comb begin
        word = '0;
        pos  = '0;
        for (int k = 0; k < 4; k++) begin
            word = word | ({field[k], 48'h0} >> {pos, 2'b00});
            pos  = pos + {2'b00, cnt[k]};
        end
    end

    assign header  = {cls[3], cls[2], cls[1], cls[0]};
    assign pos_rnd = pos + 5'd1;

    // header byte plus one byte per nibble pair
    assign o_entry.header  = header;
    assign o_entry.nibbles = word;
    assign o_entry.nbytes  = NBYTES_W'(pos_rnd[4:1]) + NBYTES_W'(1);

endmodule

// ===== hdl/fvnp_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on fvnp_pkg.
module fvnp_queue import fvnp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_pack_entry i_entry,
    input  logic        i_pop,
    output t_pack_entry o_head,
    output t_q_stat     o_stat
);

    t_pack_entry       r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rptr];

    // pointer and fill count update
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = r_wptr + QPTR_W'(1);
        end
        if (i_pop) begin
            n_rptr = r_rptr + QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != QCNT_W'(QDEPTH)) |-> (r_wptr != r_rptr))
        else $error("queue pointers disagree with count");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");

endmodule

// ===== hdl/fvnp_back.sv =====
// Back of the packer: serializes the head entry one byte per beat into an output register.
// Depends on fvnp_pkg.
module fvnp_back import fvnp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_pack_entry i_head,
    input  t_q_stat     i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_last
);

    logic [NBYTES_W-1:0] r_idx, n_idx;
    logic                r_valid;
    logic [7:0]          r_byte;
    logic                r_last;
    logic                load;
    logic                take;
    logic                is_last;
    logic [2:0]          bsel;
    logic [NIB_W-1:0]    shifted;
    logic [7:0]          sel_byte;

    // output register frees when empty or when its beat is taken
    assign load = !r_valid || !i_stall;
    assign take = load && !i_qstat.empty;

    // byte selection: header first, then nibble pairs from the top
    assign bsel     = 3'(r_idx - NBYTES_W'(1));
    assign shifted  = i_head.nibbles << {bsel, 3'b000};
    assign sel_byte = (r_idx == '0) ? i_head.header : shifted[NIB_W-1 -: 8];
    assign is_last  = (r_idx == i_head.nbytes - NBYTES_W'(1));

    assign o_pop = take && is_last;

    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = is_last ? '0 : r_idx + NBYTES_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= !i_qstat.empty;
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_byte <= sel_byte;
            r_last <= is_last;
        end
    end

    assign o_valid    = r_valid;
    assign o_out_byte = r_byte;
    assign o_is_last  = r_last;

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> (r_idx < i_head.nbytes))
        else $error("byte index beyond entry length");

    a_idx_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qstat.empty |-> (r_idx == '0))
        else $error("byte index not cleared while queue empty");

    a_item_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_last && !i_stall) |=> r_valid)
        else $error("gap inside an item's byte stream");

endmodule

// ===== tb/tb_four_value_nibble_packer.sv =====
// Self-checking testbench for four_value_nibble_packer: directed table, then random beats.
// Depends on fvnp_pkg for the class codes and on the four_value_nibble_packer RTL.
`timescale 1ns / 100ps

module tb_four_value_nibble_packer;
    import fvnp_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_PER_PHASE = 26;
    localparam int NUM_DIRECTED   = 22;

    // One expected output beat
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_encoded_byte;

    // Directed row: four values, typed byte count (0 = use predictor), bytes right aligned
    typedef struct packed {
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] c;
        logic [15:0] d;
        logic [3:0]  nexp;
        logic [71:0] exp;
    } t_directed_row;

    localparam logic [139:0] DIRECTED_ROWS [0:NUM_DIRECTED-1] = '{
        // all zero: header only
        {16'h0000, 16'h0000, 16'h0000, 16'h0000, 4'd1, 72'h00},
        // class edges on value_a
        {16'h0001, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h01_10},
        {16'hFFF8, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h01_80},
        {16'h0007, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h01_70},
        {16'h0008, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h02_08},
        {16'hFFF7, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h02_F7},
        {16'h007F, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h02_7F},
        {16'hFF80, 16'h0000, 16'h0000, 16'h0000, 4'd2, 72'h02_80},
        {16'h0080, 16'h0000, 16'h0000, 16'h0000, 4'd3, 72'h03_0080},
        {16'hFF7F, 16'h0000, 16'h0000, 16'h0000, 4'd3, 72'h03_FF7F},
        // extremes: longest streams
        {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 4'd9, 72'hFF_7FFF_7FFF_7FFF_7FFF},
        {16'h8000, 16'h8000, 16'h8000, 16'h8000, 4'd9, 72'hFF_8000_8000_8000_8000},
        {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd3, 72'h55_FFFF},
        // header position of each value, odd nibble padding
        {16'h0000, 16'h0005, 16'h0000, 16'h0000, 4'd2, 72'h04_50},
        {16'h0000, 16'h0000, 16'h1234, 16'h0000, 4'd3, 72'h30_1234},
        {16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 4'd2, 72'h40_F0},
        // mixed rows, checked against the predictor
        {16'h0003, 16'h0012, 16'h0000, 16'h0000, 4'd0, 72'h0},
        {16'h1234, 16'hFFFB, 16'h0056, 16'h0000, 4'd0, 72'h0},
        {16'hFF81, 16'h0000, 16'hABCD, 16'h0007, 4'd0, 72'h0},
        {16'h0000, 16'h8001, 16'h0000, 16'hFFF9, 4'd0, 72'h0},
        {16'h5555, 16'hAAAA, 16'h00F0, 16'hFF0F, 4'd0, 72'h0},
        {16'h0FFF, 16'hF000, 16'h0001, 16'hFFFE, 4'd0, 72'h0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic signed [15:0] i_value_a;
    logic signed [15:0] i_value_b;
    logic signed [15:0] i_value_c;
    logic signed [15:0] i_value_d;
    logic               o_valid;
    logic               i_stall;
    logic [7:0]         o_out_byte;
    logic               o_is_last;

    t_encoded_byte pending_bytes [$];
    int            mismatch_count = 0;
    int            quiet_cycles   = 0;
    int            src_idle_pct   = 14;
    int            snk_idle_pct   = 81;

    four_value_nibble_packer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value_a  (i_value_a),
        .i_value_b  (i_value_b),
        .i_value_c  (i_value_c),
        .i_value_d  (i_value_d),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_byte (o_out_byte),
        .o_is_last  (o_is_last)
    );

    // 10 ns clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Class code of one value
    function automatic logic [1:0] class_of_value(input logic [15:0] raw);
        logic signed [15:0] s;
        s = raw;
        if (s == 16'sd0)
            return CLS_ZERO;
        if (s >= -16'sd8 && s <= 16'sd7)
            return CLS_NIB1;
        if (s >= -16'sd128 && s <= 16'sd127)
            return CLS_NIB2;
        return CLS_NIB4;
    endfunction

    function automatic int nibbles_of_class(input logic [1:0] cls);
        case (cls)
            CLS_ZERO: return 0;
            CLS_NIB1: return 1;
            CLS_NIB2: return 2;
            default:  return 4;
        endcase
    endfunction

    // Predict the byte stream of one beat and queue it
    task automatic push_encoding(input logic [15:0] a, input logic [15:0] b,
                                 input logic [15:0] c, input logic [15:0] d);
        logic [15:0]   vals [4];
        logic [3:0]    nibs [$];
        logic [7:0]    header;
        logic [1:0]    cls;
        logic [3:0]    lo;
        int            cnt;
        t_encoded_byte eb;
        vals[0] = a;
        vals[1] = b;
        vals[2] = c;
        vals[3] = d;
        header  = 8'h00;
        for (int i = 0; i < 4; i++) begin
            cls = class_of_value(vals[i]);
            header[2*i +: 2] = cls;
            cnt = nibbles_of_class(cls);
            for (int j = cnt - 1; j >= 0; j--)
                nibs.push_back(vals[i][4*j +: 4]);
        end
        eb.data = header;
        eb.last = (nibs.size() == 0);
        pending_bytes.push_back(eb);
        // earlier nibble in the high half, odd tail padded with zero
        for (int k = 0; k < nibs.size(); k += 2) begin
            lo = (k + 1 < nibs.size()) ? nibs[k+1] : 4'h0;
            eb.data = {nibs[k], lo};
            eb.last = (k + 2 >= nibs.size());
            pending_bytes.push_back(eb);
        end
    endtask

    // Drive one beat from a falling edge, wait for acceptance, queue its expectation
    task automatic send_values(input logic [15:0] a, input logic [15:0] b,
                               input logic [15:0] c, input logic [15:0] d,
                               input logic [3:0] nexp, input logic [71:0] exp);
        t_encoded_byte eb;
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_value_a <= a;
        i_value_b <= b;
        i_value_c <= c;
        i_value_d <= d;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        if (nexp == 4'd0) begin
            push_encoding(a, b, c, d);
        end else begin
            for (int k = 0; k < nexp; k++) begin
                eb.data = exp[8*(nexp-1-k) +: 8];
                eb.last = (k == nexp - 1);
                pending_bytes.push_back(eb);
            end
        end
        @(negedge i_clk);
    endtask

    // Random value of a given class, boundaries included
    function automatic logic [15:0] pick_in_class(input logic [1:0] cls);
        int v;
        case (cls)
            CLS_ZERO: return 16'h0000;
            CLS_NIB1: begin
                v = $urandom_range(14);
                return (v < 7) ? 16'(v + 1) : 16'(-(v - 6));
            end
            CLS_NIB2: begin
                v = $urandom_range(239);
                return (v < 120) ? 16'(v + 8) : 16'(-(v - 111));
            end
            default: return 16'($urandom_range(65279) + 128);
        endcase
    endfunction

    // Receiver stall
    always @(negedge i_clk)
        i_stall <= ($urandom_range(99) < snk_idle_pct);

    // Output checker
    always @(posedge i_clk) begin
        t_encoded_byte eb;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_bytes.size() == 0) begin
                $error("unexpected output beat: out_byte %h, is_last %b", o_out_byte, o_is_last);
                mismatch_count++;
            end else begin
                eb = pending_bytes.pop_front();
                if (o_out_byte !== eb.data) begin
                    $error("out_byte mismatch: expected %h, actual %h", eb.data, o_out_byte);
                    mismatch_count++;
                end
                if (o_is_last !== eb.last) begin
                    $error("is_last mismatch: expected %b, actual %b", eb.last, o_is_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_stall === 1'b0) || (o_valid === 1'b1 && i_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_directed_row row;
        logic [15:0]   rv [4];
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_value_a = '0;
        i_value_b = '0;
        i_value_c = '0;
        i_value_d = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed table
        for (int r = 0; r < NUM_DIRECTED; r++) begin
            row = t_directed_row'(DIRECTED_ROWS[r]);
            send_values(row.a, row.b, row.c, row.d, row.nexp, row.exp);
        end

        // random phases: slow receiver, slow sender, no idling
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin src_idle_pct = 14; snk_idle_pct = 81; end
                1: begin src_idle_pct = 81; snk_idle_pct = 14; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                for (int i = 0; i < 4; i++)
                    rv[i] = ($urandom_range(7) == 0) ? 16'($urandom)
                                                     : pick_in_class(2'($urandom_range(3)));
                send_values(rv[0], rv[1], rv[2], rv[3], 4'd0, 72'h0);
            end
            // hold off until the queue of expected bytes is empty
            i_valid <= 1'b0;
            while (pending_bytes.size() != 0)
                @(negedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_bytes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
